FILE: rtl/hmm_viterbi_midpoint_segment_assert.svh
// ----------------------------------------------------------------------------
// hmm viterbi midpoint segment assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef HMM_VITERBI_MIDPOINT_SEGMENT_ASSERT_SVH
`define HMM_VITERBI_MIDPOINT_SEGMENT_ASSERT_SVH

// antecedent holds, consequent in the same cycle
`define HVMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hvms assertion failed");

// antecedent holds, consequent in the next cycle
`define HVMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hvms assertion failed");

`endif

FILE: rtl/hvms_pkg.sv
// ----------------------------------------------------------------------------
// hvms_pkg
// types, constants and saturating arithmetic for the viterbi segment block
// ----------------------------------------------------------------------------
package hvms_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 64;
    localparam int SCORE_BITS  = 32;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 48;

    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    localparam score_t SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam score_t SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

    localparam cnt_t STATES_MIN = cnt_t'(2);
    localparam cnt_t STATES_MAX = cnt_t'(NUM_STATES);

    typedef enum logic [1:0] {
        REQ_TRANS = 2'd0,
        REQ_EMIT  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_OBS   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FIRST,
        ST_SCAN,
        ST_COMMIT,
        ST_FIND,
        ST_DONE
    } fsm_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic   wr_trans;
        logic   wr_emit;
        logic   wr_init;
        idx_t   wr_row;
        idx_t   wr_col;
        score_t wr_val;
        idx_t   trans_addr;
        idx_t   emit_addr;
        logic   shift;
        logic   acc_en;
        idx_t   acc_k;
        score_t bc_score;
        idx_t   bc_ptr;
        logic   init_commit;
        logic   scan_commit;
        logic   use_prior;
        idx_t   prior;
        logic   mark;
        logic   tracking;
        cnt_t   s_used;
    } hvms_ctrl_t;

    // log(0) is sticky, everything else saturates
    function automatic score_t sat_add(input score_t a, input score_t b);
        logic signed [SCORE_BITS:0] sum;
        score_t res;
        sum = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
        if (a == SCORE_MIN || b == SCORE_MIN)
            res = SCORE_MIN;
        else if (sum[SCORE_BITS] != sum[SCORE_BITS-1])
            res = sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
        else
            res = sum[SCORE_BITS-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/hmm_viterbi_midpoint_segment.sv
// ----------------------------------------------------------------------------
// hmm_viterbi_midpoint_segment
// log-domain viterbi over one segment with midpoint tracking, row of acs cells
// ----------------------------------------------------------------------------
// table load: written straight from idle, input side stays ready
// first observation: prep, then the initial-score commit; later observations:
// prep, a 64-step rotation of the score column through the cell chain, commit
// last observation adds an end-state scan, then the result once output is free
// rst_n clears control and the state count (64); tables and scores undefined
module hmm_viterbi_midpoint_segment
    import hvms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data,      // states_in_use
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row_index, col_index, log_value, symbol, first_item, use_prior,
    // prior_state, mark_mid, end_known, end_state, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,       // req_type
    input  logic                 s_tlast,       // last_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // final_state, mid_state, best_score, end_searched, zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    fsm_t   state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    cnt_t   scfg_reg;
    cnt_t   s_used;
    logic   tracking_reg, tracking_next;

    idx_t   sym_reg, prior_reg, end_reg;
    logic   first_reg, use_prior_reg, mark_reg, last_reg, known_reg;

    score_t bc_score_reg;
    idx_t   bc_ptr_reg, bc_k_reg;
    logic   bc_valid_reg, bc_valid_next;

    score_t fbest_reg;
    idx_t   fin_reg, fptr_reg;
    logic   find_upd;

    logic   m_tvalid_reg;
    logic   [M_TDATA_W-1:0] m_tdata_reg;
    logic   out_load;

    hvms_ctrl_t ctrl;
    score_t score_q [NUM_STATES];
    idx_t   ptr_q   [NUM_STATES];

    logic   in_acc;
    logic   obs_acc;

    assign in_acc    = s_tvalid && s_tready;
    assign obs_acc   = in_acc && (req_t'(s_tuser) == REQ_OBS);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        if (scfg_reg < STATES_MIN)
            s_used = STATES_MIN;
        else if (scfg_reg > STATES_MAX)
            s_used = STATES_MAX;
        else
            s_used = scfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scfg_reg <= STATES_MAX;
        else if (cfg_valid && cfg_ready)
            scfg_reg <= cfg_data;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            tracking_reg <= 1'b0;
            bc_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            tracking_reg <= tracking_next;
            bc_valid_reg <= bc_valid_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        tracking_next    = tracking_reg;
        bc_valid_next    = 1'b0;
        out_load         = 1'b0;
        find_upd         = 1'b0;

        ctrl             = '0;
        ctrl.wr_row      = s_tdata[5:0];
        ctrl.wr_col      = s_tdata[11:6];
        ctrl.wr_val      = s_tdata[43:12];
        ctrl.trans_addr  = prior_reg;
        ctrl.emit_addr   = sym_reg;
        ctrl.acc_en      = bc_valid_reg;
        ctrl.acc_k       = bc_k_reg;
        ctrl.bc_score    = bc_score_reg;
        ctrl.bc_ptr      = bc_ptr_reg;
        ctrl.use_prior   = use_prior_reg;
        ctrl.prior       = prior_reg;
        ctrl.mark        = mark_reg;
        ctrl.tracking    = tracking_reg;
        ctrl.s_used      = s_used;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (req_t'(s_tuser))
                        REQ_TRANS: ctrl.wr_trans = 1'b1;
                        REQ_EMIT:  ctrl.wr_emit  = 1'b1;
                        REQ_INIT:  ctrl.wr_init  = 1'b1;
                        REQ_OBS:   state_next    = ST_PREP;
                    endcase
                end
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = first_reg ? ST_FIRST : ST_SCAN;
            end
            ST_FIRST:
            begin
                ctrl.init_commit = 1'b1;
                tracking_next    = mark_reg;
                cnt_next         = '0;
                state_next       = last_reg ? ST_FIND : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (cnt_reg < STATES_MAX)
                begin
                    ctrl.trans_addr = cnt_reg[IDX_W-1:0];
                    ctrl.shift      = 1'b1;
                    bc_valid_next   = cnt_reg < s_used;
                    cnt_next        = cnt_reg + cnt_t'(1);
                end
                else
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                ctrl.scan_commit = 1'b1;
                if (mark_reg)
                    tracking_next = 1'b1;
                cnt_next   = '0;
                state_next = last_reg ? ST_FIND : ST_IDLE;
            end
            ST_FIND:
            begin
                ctrl.shift = 1'b1;
                if (known_reg)
                    find_upd = cnt_reg[IDX_W-1:0] == end_reg;
                else
                    find_upd = (cnt_reg == '0) ||
                               ((cnt_reg < s_used) && (fbest_reg < score_q[0]));
                cnt_next = cnt_reg + cnt_t'(1);
                if (cnt_reg == STATES_MAX - cnt_t'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // observation fields held for the whole transaction
    always_ff @(posedge clk)
    begin
        if (obs_acc)
        begin
            sym_reg       <= s_tdata[49:44];
            first_reg     <= s_tdata[50];
            use_prior_reg <= s_tdata[51];
            prior_reg     <= s_tdata[57:52];
            mark_reg      <= s_tdata[58];
            known_reg     <= s_tdata[59];
            end_reg       <= s_tdata[65:60];
            last_reg      <= s_tlast;
        end
    end

    // head of the chain, delayed to line up with the registered memory read
    always_ff @(posedge clk)
    begin
        bc_score_reg <= score_q[0];
        bc_ptr_reg   <= ptr_q[0];
        bc_k_reg     <= cnt_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (find_upd)
        begin
            fbest_reg <= score_q[0];
            fin_reg   <= cnt_reg[IDX_W-1:0];
            fptr_reg  <= ptr_q[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {3'b000, !known_reg, fbest_reg,
                            tracking_reg ? fptr_reg : idx_t'(0), fin_reg};
    end

    for (genvar g = 0; g < NUM_STATES; g++)
    begin : g_cell
        hvms_cell u_cell (
            .clk      (clk),
            .cell_idx (idx_t'(g)),
            .ctrl     (ctrl),
            .nb_score (score_q[(g + 1) % NUM_STATES]),
            .nb_ptr   (ptr_q[(g + 1) % NUM_STATES]),
            .score_q  (score_q[g]),
            .ptr_q    (ptr_q[g])
        );
    end

endmodule

FILE: rtl/hvms_cell.sv
// ----------------------------------------------------------------------------
// hvms_cell
// one state of the trellis: its transition column, emission row, initial
// value, score and midpoint pointer, plus the add-compare-select accumulator
// ----------------------------------------------------------------------------
module hvms_cell
    import hvms_pkg::*;
(
    input  logic       clk,
    input  idx_t       cell_idx,
    input  hvms_ctrl_t ctrl,
    input  score_t     nb_score,
    input  idx_t       nb_ptr,
    output score_t     score_q,
    output idx_t       ptr_q
);

    score_t trans_mem [NUM_STATES];
    score_t emit_mem  [NUM_SYMBOLS];

    score_t trans_rd_reg;
    score_t emit_rd_reg;
    score_t init_reg;
    score_t score_reg;
    idx_t   ptr_reg;
    score_t best_reg;
    idx_t   arg_reg;
    idx_t   aptr_reg;

    logic   in_use;
    score_t cand;
    score_t base;

    assign in_use = {1'b0, cell_idx} < ctrl.s_used;
    assign cand   = sat_add(sat_add(ctrl.bc_score, trans_rd_reg), emit_rd_reg);
    assign base   = ctrl.use_prior ? trans_rd_reg : init_reg;

    // column of trans: entry [k][cell_idx] lives at address k
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_trans && ctrl.wr_col == cell_idx)
            trans_mem[ctrl.wr_row] <= ctrl.wr_val;
        trans_rd_reg <= trans_mem[ctrl.trans_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_emit && ctrl.wr_row == cell_idx)
            emit_mem[ctrl.wr_col] <= ctrl.wr_val;
        emit_rd_reg <= emit_mem[ctrl.emit_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_init && ctrl.wr_row == cell_idx)
            init_reg <= ctrl.wr_val;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en && (ctrl.acc_k == '0 || best_reg < cand))
        begin
            best_reg <= cand;
            arg_reg  <= ctrl.acc_k;
            aptr_reg <= ctrl.bc_ptr;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (ctrl.shift)
        begin
            score_reg <= nb_score;
            ptr_reg   <= nb_ptr;
        end
        else if (ctrl.init_commit)
        begin
            score_reg <= in_use ? sat_add(base, emit_rd_reg) : SCORE_MIN;
            ptr_reg   <= (ctrl.mark && ctrl.use_prior) ? ctrl.prior : '0;
        end
        else if (ctrl.scan_commit)
        begin
            score_reg <= in_use ? best_reg : SCORE_MIN;
            if (!in_use)
                ptr_reg <= '0;
            else if (ctrl.mark)
                ptr_reg <= arg_reg;
            else if (ctrl.tracking)
                ptr_reg <= aptr_reg;
            else
                ptr_reg <= '0;
        end
        else
        begin
            score_reg <= score_reg;
            ptr_reg   <= ptr_reg;
        end
    end

    assign score_q = score_reg;
    assign ptr_q   = ptr_reg;

endmodule

FILE: rtl/hvms_checker.sv
// ----------------------------------------------------------------------------
// hvms_checker
// port-level checks on the viterbi segment block, bound to the top level
// ----------------------------------------------------------------------------
`include "hmm_viterbi_midpoint_segment_assert.svh"

module hvms_checker
    import hvms_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic load_acc;
    logic obs_acc;

    assign load_acc = s_tvalid && s_tready && (req_t'(s_tuser) != REQ_OBS);
    assign obs_acc  = s_tvalid && s_tready && (req_t'(s_tuser) == REQ_OBS);

    // a result waiting for its transaction stays up
    `HVMS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    // after a table load the input side is ready again
    `HVMS_ASSERT_NEXT(a_load_fast, clk, rst_n, load_acc, s_tready)
    // an observation keeps the input side busy
    `HVMS_ASSERT_NEXT(a_obs_busy, clk, rst_n, obs_acc, !s_tready)
    // pad bits of the result are zero
    `HVMS_ASSERT_NOW(a_out_pad, clk, rst_n, m_tvalid, m_tdata[47:45] == 3'b000)

endmodule

bind hmm_viterbi_midpoint_segment hvms_checker u_hvms_checker (.*);
